// ----- hw/rtl/sorted_module_table_update_top_assert.svh -----
// Assertion macros for the sorted module table RTL.
// Depends on nothing; included by the top level, the one file with checks.
`ifndef SORTED_MODULE_TABLE_UPDATE_TOP_ASSERT_SVH
`define SORTED_MODULE_TABLE_UPDATE_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SMTU_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted module table check failed");

// Next-cycle implication, switched off while reset is asserted.
`define SMTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted module table check failed");

`endif

// ----- hw/rtl/smtu_pkg.sv -----
// Types, codes and constants for the sorted module table.
// Used by smtu_cell and sorted_module_table_update_top; depends on nothing.
package smtu_pkg;

    localparam int MAX_MODULES_DEF = 8;

    localparam logic [7:0] ATTACH_LEN = 8'd12;
    localparam logic [7:0] DETACH_LEN = 8'd2;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_TOO_SHORT   = 3'd1;
    localparam logic [2:0] STATUS_BAD_DETACH  = 3'd2;
    localparam logic [2:0] STATUS_BAD_ATTACH  = 3'd3;
    localparam logic [2:0] STATUS_UNKNOWN     = 3'd4;
    localparam logic [2:0] STATUS_FULL        = 3'd5;

    typedef struct packed {
        logic [7:0]  packet_length;
        logic [7:0]  connect_id;
        logic [7:0]  attach_byte;
        logic [7:0]  hub_index;
        logic [7:0]  module_type;
        logic [31:0] hardware_revision;
        logic [31:0] firmware_revision;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        changed;
        logic [3:0]  module_count;
        logic        entry_present;
        logic [7:0]  entry_connect_id;
        logic [7:0]  entry_hub_index;
        logic [7:0]  entry_type;
        logic [31:0] entry_hardware_revision;
        logic [31:0] entry_firmware_revision;
        logic        last_of_run;
    } out_word_t;

    // Hub index sits above connect id, so the pair compares as the sort key.
    typedef struct packed {
        logic [7:0]  hub_index;
        logic [7:0]  connect_id;
        logic [7:0]  module_type;
        logic [31:0] hw_revision;
        logic [31:0] fw_revision;
    } entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_DOWN,
        CELL_SHIFT_UP,
        CELL_LOAD,
        CELL_RING
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctl_t;

    typedef struct packed {
        logic id_match;
        logic key_less;
    } cell_flags_t;

endpackage

// ----- hw/rtl/sorted_module_table_update_top.sv -----
// Sorted module table top level: handshake, sequencing and listing.
// Depends on smtu_pkg, smtu_cell and sorted_module_table_update_top_assert.svh.

// The block keeps up to MAX_MODULES attached modules in a row of cells, ordered
// by hub index and then by connect id, with cell 0 holding the smallest key.
// Each input word is one attach or detach notification with its length. In the
// cycle after acceptance the length is checked and the matching entry, if any,
// is taken out by shifting the cells above it down by one; the next cycle a
// valid attach is written into its sorted place by shifting the larger entries
// up by one. The table is then listed through cell 0: the active cells rotate
// as a ring, one entry per output word, and after a full turn they are back in
// order. An empty table gives a single word with entry_present low. Status,
// changed and module_count repeat on every word of one notification, and
// last_of_run marks the final one. The ring turns only while the output
// register is empty or its word is being taken. A finished word waits in
// the output register, and the next notification is accepted while it
// waits. No new word is accepted until the listing has finished.
`include "sorted_module_table_update_top_assert.svh"

module sorted_module_table_update_top #(
    parameter int MAX_MODULES = smtu_pkg::MAX_MODULES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  smtu_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output smtu_pkg::out_word_t out_data
);

    localparam int CNT_W = $clog2(MAX_MODULES + 1);

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_INSERT = 4'b0100,
        S_LIST   = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    smtu_pkg::in_word_t  item_reg;
    smtu_pkg::in_word_t  item_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    list_cnt_reg;
    logic [CNT_W-1:0]    list_cnt_next;
    logic [2:0]          status_reg;
    logic [2:0]          status_next;
    logic                changed_reg;
    logic                changed_next;
    logic                insert_reg;
    logic                insert_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    smtu_pkg::out_word_t out_reg;
    smtu_pkg::out_word_t out_next;

    smtu_pkg::entry_t      cell_entry [MAX_MODULES];
    smtu_pkg::cell_flags_t cell_flags [MAX_MODULES];
    smtu_pkg::cell_ctl_t   cell_ctl   [MAX_MODULES];
    smtu_pkg::entry_t      new_entry;

    logic [MAX_MODULES-1:0] active;
    logic [MAX_MODULES-1:0] match;
    logic [MAX_MODULES-1:0] less;
    logic [MAX_MODULES-1:0] at_or_after;
    logic [MAX_MODULES-1:0] prev_less;

    logic found;
    logic is_attach;
    logic table_full;
    logic remove_go;
    logic list_load;
    logic list_last;

    assign new_entry.hub_index   = item_reg.hub_index;
    assign new_entry.connect_id  = item_reg.connect_id;
    assign new_entry.module_type = item_reg.module_type;
    assign new_entry.hw_revision = item_reg.hardware_revision;
    assign new_entry.fw_revision = item_reg.firmware_revision;

    // The row of cells; each one sees its two neighbours and cell 0 for the ring.
    for (genvar i = 0; i < MAX_MODULES; i++)
    begin : g_cell
        smtu_pkg::entry_t lower_entry;
        smtu_pkg::entry_t upper_entry;

        if (i == 0)
        begin : g_first
            assign lower_entry = cell_entry[0];
            assign prev_less[0] = 1'b1;
            assign at_or_after[0] = match[0];
        end
        else
        begin : g_rest
            assign lower_entry = cell_entry[i-1];
            assign prev_less[i] = less[i-1];
            assign at_or_after[i] = at_or_after[i-1] | match[i];
        end

        if (i == MAX_MODULES - 1)
        begin : g_last
            assign upper_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign upper_entry = cell_entry[i+1];
        end

        assign active[i] = (CNT_W'(i) < count_reg);
        assign match[i]  = active[i] & cell_flags[i].id_match;
        assign less[i]   = active[i] & cell_flags[i].key_less;

        smtu_cell u_cell (
            .clk         (clk),
            .ctl         (cell_ctl[i]),
            .new_entry   (new_entry),
            .lower_entry (lower_entry),
            .upper_entry (upper_entry),
            .ring_entry  (cell_entry[0]),
            .probe_id    (item_reg.connect_id),
            .probe_key   ({item_reg.hub_index, item_reg.connect_id}),
            .entry       (cell_entry[i]),
            .flags       (cell_flags[i])
        );
    end

    assign found      = |match;
    assign is_attach  = (item_reg.attach_byte != 8'd0);
    assign table_full = (count_reg == CNT_W'(MAX_MODULES));

    // A valid detach of a known module, or an attach that replaces one.
    assign remove_go = found && (item_reg.packet_length >= smtu_pkg::DETACH_LEN) &&
                       (is_attach ? (item_reg.packet_length == smtu_pkg::ATTACH_LEN)
                                  : (item_reg.packet_length == smtu_pkg::DETACH_LEN));

    assign list_load = (state_reg == S_LIST) && (!out_valid_reg || out_ready);
    assign list_last = (count_reg == '0) || (CNT_W'(list_cnt_reg + 1'b1) == count_reg);

    // Per-cell moves for each phase.
    always_comb
    begin
        for (int i = 0; i < MAX_MODULES; i++)
        begin
            cell_ctl[i].op = smtu_pkg::CELL_HOLD;
            if (state_reg == S_DECIDE)
            begin
                if (remove_go && at_or_after[i] && (i < MAX_MODULES - 1))
                    cell_ctl[i].op = smtu_pkg::CELL_SHIFT_DOWN;
            end
            else if (state_reg == S_INSERT)
            begin
                if (insert_reg && !less[i])
                    cell_ctl[i].op = prev_less[i] ? smtu_pkg::CELL_LOAD
                                                  : smtu_pkg::CELL_SHIFT_UP;
            end
            else if (list_load && active[i])
            begin
                if (CNT_W'(i + 1) == count_reg)
                    cell_ctl[i].op = smtu_pkg::CELL_RING;
                else
                    cell_ctl[i].op = smtu_pkg::CELL_SHIFT_DOWN;
            end
        end
    end

    // Sequencer and status decision.
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        count_next    = count_reg;
        list_cnt_next = list_cnt_reg;
        status_next   = status_reg;
        changed_next  = changed_reg;
        insert_next   = insert_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                status_next  = smtu_pkg::STATUS_OK;
                changed_next = 1'b0;
                insert_next  = 1'b0;
                if (item_reg.packet_length < smtu_pkg::DETACH_LEN)
                    status_next = smtu_pkg::STATUS_TOO_SHORT;
                else if (!is_attach)
                begin
                    if (item_reg.packet_length != smtu_pkg::DETACH_LEN)
                        status_next = smtu_pkg::STATUS_BAD_DETACH;
                    else if (!found)
                        status_next = smtu_pkg::STATUS_UNKNOWN;
                    else
                        changed_next = 1'b1;
                end
                else if (item_reg.packet_length != smtu_pkg::ATTACH_LEN)
                    status_next = smtu_pkg::STATUS_BAD_ATTACH;
                else if (!found && table_full)
                    status_next = smtu_pkg::STATUS_FULL;
                else
                begin
                    changed_next = 1'b1;
                    insert_next  = 1'b1;
                end
                if (remove_go)
                    count_next = CNT_W'(count_reg - 1'b1);
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                if (insert_reg)
                    count_next = CNT_W'(count_reg + 1'b1);
                list_cnt_next = '0;
                state_next    = S_LIST;
            end
            S_LIST:
            begin
                if (list_load)
                begin
                    list_cnt_next = CNT_W'(list_cnt_reg + 1'b1);
                    if (list_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word, taken from cell 0 while the ring turns.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (list_load)
        begin
            out_valid_next                   = 1'b1;
            out_next.status                  = status_reg;
            out_next.changed                 = changed_reg;
            out_next.module_count            = 4'(count_reg);
            out_next.entry_present           = (count_reg != '0);
            out_next.entry_connect_id        = '0;
            out_next.entry_hub_index         = '0;
            out_next.entry_type              = '0;
            out_next.entry_hardware_revision = '0;
            out_next.entry_firmware_revision = '0;
            out_next.last_of_run             = list_last;
            if (count_reg != '0)
            begin
                out_next.entry_connect_id        = cell_entry[0].connect_id;
                out_next.entry_hub_index         = cell_entry[0].hub_index;
                out_next.entry_type              = cell_entry[0].module_type;
                out_next.entry_hardware_revision = cell_entry[0].hw_revision;
                out_next.entry_firmware_revision = cell_entry[0].fw_revision;
            end
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            list_cnt_reg  <= '0;
            status_reg    <= smtu_pkg::STATUS_OK;
            changed_reg   <= 1'b0;
            insert_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            list_cnt_reg  <= list_cnt_next;
            status_reg    <= status_next;
            changed_reg   <= changed_next;
            insert_reg    <= insert_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The table never holds more entries than there are cells.
    `SMTU_ASSERT(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_MODULES))
    // Connect ids are unique among the active cells.
    `SMTU_ASSERT(a_match_unique, clk, rst_n, state_reg == S_DECIDE, $onehot0(match))
    // An accepted word always starts the decision step.
    `SMTU_ASSERT_NEXT(a_accept_decide, clk, rst_n, in_valid && in_ready,
                      state_reg == S_DECIDE)
    // The last listed word closes the run and frees the input side.
    `SMTU_ASSERT_NEXT(a_last_idle, clk, rst_n, list_load && list_last,
                      state_reg == S_IDLE && out_valid_reg && out_data.last_of_run)

endmodule

// ----- hw/rtl/smtu_cell.sv -----
// One slot of the sorted module table: holds an entry and compares it.
// Depends on smtu_pkg.
module smtu_cell (
    input  logic                 clk,
    input  smtu_pkg::cell_ctl_t  ctl,
    input  smtu_pkg::entry_t     new_entry,
    input  smtu_pkg::entry_t     lower_entry,
    input  smtu_pkg::entry_t     upper_entry,
    input  smtu_pkg::entry_t     ring_entry,
    input  logic [7:0]           probe_id,
    input  logic [15:0]          probe_key,
    output smtu_pkg::entry_t     entry,
    output smtu_pkg::cell_flags_t flags
);

    smtu_pkg::entry_t entry_reg;
    smtu_pkg::entry_t entry_next;

    always_comb
    begin
        case (ctl.op)
            smtu_pkg::CELL_SHIFT_DOWN: entry_next = upper_entry;
            smtu_pkg::CELL_SHIFT_UP:   entry_next = lower_entry;
            smtu_pkg::CELL_LOAD:       entry_next = new_entry;
            smtu_pkg::CELL_RING:       entry_next = ring_entry;
            default:                   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry          = entry_reg;
    assign flags.id_match = (entry_reg.connect_id == probe_id);
    assign flags.key_less = ({entry_reg.hub_index, entry_reg.connect_id} < probe_key);

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for sorted_module_table_update_top.
// Depends on smtu_pkg and the block's RTL; it keeps its own copy of the module table
// to predict every listing word, and checks each output word as it is taken.

module testbench;

    import smtu_pkg::*;

    // The table depth the block is built with, and the number of clock cycles
    // in which no word moves on either side before the run is abandoned.
    localparam int TABLE_DEPTH = MAX_MODULES_DEF;
    localparam int QUIET_LIMIT = 2000;
    // Cycles allowed after the last expected word, so that a stray extra word is caught.
    localparam int TAIL_CYCLES = 24;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    // The model of the table, kept sorted by hub index and then by connect id,
    // and the listing words that the block still owes us, oldest first.
    entry_t    mod_rows[$];
    out_word_t pending_listing[$];

    int  fail_count;
    bit  idle_on;
    int  stall_left;
    int  quiet_cycles;

    sorted_module_table_update_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Works out what the block must do with one notification: it updates the
    // model of the table and queues one listing word per entry, or a single
    // word with entry_present low when the table has ended up empty.
    function automatic void predict_listing(input in_word_t w);
        logic [2:0]  st;
        logic        chg;
        int          pos;
        int          ins;
        int          words;
        logic [15:0] key;
        entry_t      fresh;
        out_word_t   o;
        st  = STATUS_OK;
        chg = 1'b0;
        pos = -1;
        // Detach and replace both look the module up by connect id alone.
        foreach (mod_rows[i])
        begin
            if (pos < 0 && mod_rows[i].connect_id == w.connect_id)
                pos = i;
        end
        if (w.packet_length < DETACH_LEN)
            st = STATUS_TOO_SHORT;
        else if (w.attach_byte == 8'd0)
        begin
            if (w.packet_length != DETACH_LEN)
                st = STATUS_BAD_DETACH;
            else if (pos < 0)
                st = STATUS_UNKNOWN;
            else
            begin
                mod_rows.delete(pos);
                chg = 1'b1;
            end
        end
        else if (w.packet_length != ATTACH_LEN)
            st = STATUS_BAD_ATTACH;
        else if (pos < 0 && mod_rows.size() >= TABLE_DEPTH)
            st = STATUS_FULL;
        else
        begin
            // A replacement takes the old entry out first, since its hub
            // index may have changed and with it its place in the order.
            if (pos >= 0)
                mod_rows.delete(pos);
            key = {w.hub_index, w.connect_id};
            ins = 0;
            while (ins < mod_rows.size() &&
                   {mod_rows[ins].hub_index, mod_rows[ins].connect_id} < key)
                ins++;
            fresh.hub_index   = w.hub_index;
            fresh.connect_id  = w.connect_id;
            fresh.module_type = w.module_type;
            fresh.hw_revision = w.hardware_revision;
            fresh.fw_revision = w.firmware_revision;
            mod_rows.insert(ins, fresh);
            chg = 1'b1;
        end
        words = (mod_rows.size() == 0) ? 1 : mod_rows.size();
        for (int k = 0; k < words; k++)
        begin
            o = '0;
            o.status       = st;
            o.changed      = chg;
            o.module_count = 4'(mod_rows.size());
            if (k < mod_rows.size())
            begin
                o.entry_present           = 1'b1;
                o.entry_connect_id        = mod_rows[k].connect_id;
                o.entry_hub_index         = mod_rows[k].hub_index;
                o.entry_type              = mod_rows[k].module_type;
                o.entry_hardware_revision = mod_rows[k].hw_revision;
                o.entry_firmware_revision = mod_rows[k].fw_revision;
            end
            o.last_of_run = (k == words - 1);
            pending_listing.insert(pending_listing.size(), o);
        end
    endfunction

    function automatic in_word_t make_word(input logic [7:0] len, input logic [7:0] id,
                                           input logic [7:0] att, input logic [7:0] hub,
                                           input logic [7:0] mtype, input logic [31:0] hw,
                                           input logic [31:0] fw);
        in_word_t w;
        w.packet_length     = len;
        w.connect_id        = id;
        w.attach_byte       = att;
        w.hub_index         = hub;
        w.module_type       = mtype;
        w.hardware_revision = hw;
        w.firmware_revision = fw;
        return w;
    endfunction

    // Offers one notification word and waits until the block takes it. Valid is
    // left high afterwards, so that a word offered straight after keeps it high
    // without a second assignment in the same step; it is lowered only when a
    // gap is inserted, or at the end of the run.
    task automatic send_word(input in_word_t w);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        predict_listing(w);
    endtask

    // Compares one field and reports the difference, if there is one.
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Every output word that is taken is held against the oldest expectation.
    initial
    begin
        out_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_listing.size() == 0)
                begin
                    $display("%0t: unexpected output word, expected none, actual %0h",
                             $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = pending_listing.pop_front();
                    check_field("status", want.status, out_data.status);
                    check_field("changed", want.changed, out_data.changed);
                    check_field("module_count", want.module_count, out_data.module_count);
                    check_field("entry_present", want.entry_present, out_data.entry_present);
                    check_field("entry_connect_id", want.entry_connect_id,
                                out_data.entry_connect_id);
                    check_field("entry_hub_index", want.entry_hub_index,
                                out_data.entry_hub_index);
                    check_field("entry_type", want.entry_type, out_data.entry_type);
                    check_field("entry_hardware_revision", want.entry_hardware_revision,
                                out_data.entry_hardware_revision);
                    check_field("entry_firmware_revision", want.entry_firmware_revision,
                                out_data.entry_firmware_revision);
                    check_field("last_of_run", want.last_of_run, out_data.last_of_run);
                end
            end
        end
    end

    // The receiving side stalls in random bursts while idling is
    // enabled, and otherwise takes every word at once.
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // The watchdog: a run in which nothing moves for too long has hung.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** sorted_module_table_update_top: FAILED **");
        $finish;
    end

    // Every length error, on an empty table and so with the single empty
    // listing word, plus a detach of a module that was never attached.
    task automatic test_length_errors();
        send_word(make_word(8'd0, 8'h12, 8'h01, 8'h01, 8'h01, 32'h1, 32'h1));
        send_word(make_word(8'd1, 8'h12, 8'h00, 8'h01, 8'h01, 32'h1, 32'h1));
        send_word(make_word(8'd3, 8'h12, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0));
        send_word(make_word(8'd12, 8'h12, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0));
        send_word(make_word(8'd2, 8'h12, 8'h01, 8'h00, 8'h00, 32'h0, 32'h0));
        send_word(make_word(8'd13, 8'h12, 8'hFF, 8'h00, 8'h00, 32'h0, 32'h0));
        send_word(make_word(8'd255, 8'h12, 8'h80, 8'hFF, 8'hFF, '1, '1));
        send_word(make_word(8'd2, 8'h12, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0));
    endtask

    // Fills the table with the field extremes and with two modules that share
    // a hub, so that the connect id decides their order; then an attach of a
    // new module into a full table, a replacement that moves an entry while
    // the table is full, and an identical re-attach.
    task automatic test_fill_replace_full();
        send_word(make_word(ATTACH_LEN, 8'h00, 8'h01, 8'h00, 8'h00, 32'h0, 32'h0));
        send_word(make_word(ATTACH_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1, '1));
        send_word(make_word(ATTACH_LEN, 8'h09, 8'h80, 8'h03, 8'h21, 32'h0102_0304,
                            32'h0506_0708));
        send_word(make_word(ATTACH_LEN, 8'h04, 8'h01, 8'h03, 8'h22, 32'h1111_1111,
                            32'h2222_2222));
        send_word(make_word(ATTACH_LEN, 8'h80, 8'h7F, 8'h01, 8'h40, 32'h8000_0000,
                            32'h0000_0001));
        send_word(make_word(ATTACH_LEN, 8'h7F, 8'h02, 8'hFE, 8'h7F, 32'h7FFF_FFFF,
                            32'hFFFF_FFFE));
        send_word(make_word(ATTACH_LEN, 8'h55, 8'h01, 8'hAA, 8'h55, 32'hA5A5_A5A5,
                            32'h5A5A_5A5A));
        send_word(make_word(ATTACH_LEN, 8'hAA, 8'h01, 8'h55, 8'hAA, 32'h5A5A_5A5A,
                            32'hA5A5_A5A5));
        send_word(make_word(ATTACH_LEN, 8'h33, 8'h01, 8'h10, 8'h01, 32'h3, 32'h3));
        send_word(make_word(ATTACH_LEN, 8'h09, 8'h01, 8'h00, 8'h99, 32'hDEAD_0000,
                            32'h0000_BEEF));
        send_word(make_word(ATTACH_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1, '1));
    endtask

    // A detach whose trailing bytes carry rubbish, which must be ignored, and
    // a detach of a connect id that is not in a populated table.
    task automatic test_detach_cases();
        send_word(make_word(DETACH_LEN, 8'h55, 8'h00, 8'hFF, 8'hFF, '1, '1));
        send_word(make_word(DETACH_LEN, 8'h33, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0));
    endtask

    // Random traffic. Most words are well-formed attaches and detaches drawn
    // from a small pool of connect ids, so that replacements, removals and a
    // full table keep occurring; attach_pct tilts the table towards full or
    // towards empty. The rest are fully random words, which mostly end in
    // length errors and also exercise every bit of every field.
    task automatic test_random_churn(input int count, input int attach_pct);
        int       pick;
        in_word_t w;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            w.packet_length     = 8'($urandom);
            w.connect_id        = 8'($urandom_range(0, 11) * 23);
            w.attach_byte       = 8'($urandom);
            w.hub_index         = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                              : 8'($urandom);
            w.module_type       = 8'($urandom);
            w.hardware_revision = $urandom;
            w.firmware_revision = $urandom;
            if (pick < attach_pct)
            begin
                w.packet_length = ATTACH_LEN;
                w.attach_byte   = 8'($urandom_range(1, 255));
                if ($urandom_range(0, 4) == 0)
                    w.connect_id = 8'($urandom);
            end
            else if (pick < 85)
            begin
                w.packet_length = DETACH_LEN;
                w.attach_byte   = 8'd0;
                if (mod_rows.size() != 0 && $urandom_range(0, 9) < 7)
                    w.connect_id = mod_rows[$urandom_range(0, mod_rows.size() - 1)].connect_id;
            end
            else
                w.connect_id = 8'($urandom);
            send_word(w);
        end
    endtask

    // Reset once, the directed tests, then the random phases; the last phase
    // runs with no idling on either side. Once every word has been offered, the
    // bench waits for the outstanding listing and a short tail before the verdict.
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        fail_count = 0;
        idle_on    = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_length_errors();
        test_fill_replace_full();
        test_detach_cases();
        test_random_churn(150, 60);
        test_random_churn(150, 30);
        idle_on = 1'b0;
        test_random_churn(110, 50);

        in_valid <= 1'b0;
        while (pending_listing.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** sorted_module_table_update_top: PASSED **");
        else
            $display("** sorted_module_table_update_top: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/smtu_pkg.sv
hw/rtl/smtu_cell.sv
hw/rtl/sorted_module_table_update_top.sv
tb/sv/testbench.sv
